// ===== rtl/core/mndtf_pkg.sv =====
package mndtf_pkg;

  localparam int NOTE_COUNT = 128;
  localparam int NOTE_W     = $clog2(NOTE_COUNT);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_CTRL     = 4'hB;

  localparam logic [6:0] CC_SUSTAIN        = 7'd64;
  localparam logic [6:0] CC_ALL_NOTES_OFF  = 7'd123;

  localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_CAP = 1'b1;

  localparam logic signed [7:0] TRANSPOSE_RESET    = 8'sd12;
  localparam logic [6:0]        VELOCITY_CAP_RESET = 7'd83;

  localparam logic [3:0]  VEL_MUL     = 4'd13;
  localparam logic [11:0] VEL_RECIP20 = 12'd3277;
  localparam int          VEL_SHIFT   = 16;

  typedef struct packed {
    logic       kind;
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
  } item_t;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data1;
    logic [6:0] data2;
    logic       pedal_down;
  } result_t;

  typedef struct packed {
    logic signed [7:0] transpose;
    logic [6:0]        velocity_cap;
  } cfg_t;

  // floor(v * 13 / 20) via a fixed-point reciprocal of 20; exact for v below 128.
  function automatic logic [6:0] scale_velocity(input logic [6:0] v);
    logic [10:0] prod;
    logic [22:0] quot;
    prod = 11'(v) * 11'(VEL_MUL);
    quot = 23'(prod) * 23'(VEL_RECIP20);
    return quot[VEL_SHIFT +: 7];
  endfunction

endpackage

// ===== rtl/core/mndtf_ifs.sv =====
interface mndtf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_status;
  logic [6:0] in_data1;
  logic [6:0] in_data2;

  modport source (output valid, kind, in_status, in_data1, in_data2, input ready);
  modport sink   (input valid, kind, in_status, in_data1, in_data2, output ready);
endinterface

interface mndtf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_status;
  logic [6:0] out_data1;
  logic [6:0] out_data2;
  logic       pedal_down;

  modport source (output valid, out_status, out_data1, out_data2, pedal_down, input ready);
  modport sink   (input valid, out_status, out_data1, out_data2, pedal_down, output ready);
endinterface

interface mndtf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mndtf_pkg::CFG_IDX_W-1:0]  index;
  logic [mndtf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mndtf_cfg_regs.sv =====
module mndtf_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [mndtf_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [mndtf_pkg::CFG_DATA_W-1:0] wr_data,
  output mndtf_pkg::cfg_t                  cfg
);
  import mndtf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transpose    <= TRANSPOSE_RESET;
      cfg.velocity_cap <= VELOCITY_CAP_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TRANSPOSE:    cfg.transpose    <= signed'(wr_data);
        REG_VELOCITY_CAP: cfg.velocity_cap <= wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/mndtf_in_stage.sv =====
module mndtf_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mndtf_pkg::item_t in_item,
  input  logic             advance,
  output logic             item_valid,
  output mndtf_pkg::item_t item
);
  import mndtf_pkg::*;

  logic item_valid_next;
  logic load;

  assign in_ready = !item_valid || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    if (load) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end else begin
      item_valid_next = item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/mndtf_note_engine.sv =====
module mndtf_note_engine (
  input  logic               clk,
  input  logic               rst,
  input  mndtf_pkg::cfg_t    cfg,
  input  mndtf_pkg::item_t   item,
  input  logic               commit,
  output logic               emit,
  output mndtf_pkg::result_t result
);
  import mndtf_pkg::*;

  logic [NOTE_COUNT-1:0] held_map;
  logic [NOTE_COUNT-1:0] held_map_next;
  logic                  pedal_flag;
  logic                  pedal_flag_next;

  logic [3:0]        msg_type;
  logic signed [8:0] note;
  logic              in_range;
  logic [NOTE_W-1:0] idx;
  logic              held;
  logic              is_note;
  logic              is_on;
  logic [6:0]        scaled;
  logic [6:0]        vel;

  assign msg_type = item.status[7:4];
  assign note     = signed'({2'b00, item.data1}) + 9'(cfg.transpose);
  assign in_range = (note[8:7] == 2'b00);
  assign idx      = note[NOTE_W-1:0];
  assign held     = held_map[idx];
  assign is_note  = (msg_type == MSG_NOTE_ON) || (msg_type == MSG_NOTE_OFF);
  assign is_on    = (msg_type == MSG_NOTE_ON) && (item.data2 != 7'd0);
  assign scaled   = scale_velocity(item.data2);

  always_comb begin
    vel = scaled;
    if (vel > cfg.velocity_cap) begin
      vel = cfg.velocity_cap;
    end
    if (vel == 7'd0) begin
      vel = 7'd1;
    end
  end

  always_comb begin
    held_map_next   = held_map;
    pedal_flag_next = pedal_flag;
    emit            = 1'b0;
    result          = '{status: item.status, data1: item.data1, data2: item.data2,
                        pedal_down: pedal_flag};
    if (item.kind) begin
      held_map_next = '0;
    end else if (msg_type == MSG_CTRL) begin
      emit = 1'b1;
      if (item.data1 == CC_SUSTAIN) begin
        pedal_flag_next = item.data2[6];
      end else if (item.data1 == CC_ALL_NOTES_OFF) begin
        held_map_next = '0;
      end
      result.pedal_down = pedal_flag_next;
    end else if (!is_note) begin
      emit = 1'b1;
    end else if (in_range) begin
      if (is_on) begin
        if (!held) begin
          emit               = 1'b1;
          held_map_next[idx] = 1'b1;
          result.data1       = idx;
          result.data2       = vel;
        end
      end else if (held) begin
        emit               = 1'b1;
        held_map_next[idx] = 1'b0;
        result.status      = {MSG_NOTE_OFF, item.status[3:0]};
        result.data1       = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_map   <= '0;
      pedal_flag <= 1'b0;
    end else if (commit) begin
      held_map   <= held_map_next;
      pedal_flag <= pedal_flag_next;
    end
  end

endmodule

// ===== rtl/core/mndtf_out_stage.sv =====
module mndtf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  mndtf_pkg::result_t load_result,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output mndtf_pkg::result_t result
);
  import mndtf_pkg::*;

  logic out_valid_next;

  assign busy = out_valid && !out_ready;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= load_result;
    end
  end

endmodule

// ===== rtl/core/midi_note_dedup_transpose_filter_top.sv =====
// Channel  Direction  Carries
// midi     in         kind, in_status, in_data1, in_data2
// result   out        out_status, out_data1, out_data2, pedal_down
// cfg      in         index, data (0 = transpose, 1 = velocity_cap)
//
// One beat is accepted per cycle while the input register is empty or its item advances.
// The held-note map is read between input and output registers and written as items advance.
// An output register full and not drained stalls only items that emit; others pass through.
// Synchronous reset clears the map and pedal flag at once and loads the default registers.
module midi_note_dedup_transpose_filter_top (
  input logic         clk,
  input logic         rst,
  mndtf_in_if.sink    midi,
  mndtf_out_if.source result,
  mndtf_cfg_if.sink   cfg
);
  import mndtf_pkg::*;

  cfg_t    cfg_q;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    emit;
  logic    busy;
  logic    go;
  result_t eng_result;
  result_t out_result;

  assign cfg.ready = 1'b1;
  assign in_item   = '{kind: midi.kind, status: midi.in_status, data1: midi.in_data1,
                       data2: midi.in_data2};
  assign go        = item_valid && !(emit && busy);

  mndtf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  mndtf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (midi.valid),
    .in_ready   (midi.ready),
    .in_item    (in_item),
    .advance    (go),
    .item_valid (item_valid),
    .item       (item)
  );

  mndtf_note_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_q),
    .item   (item),
    .commit (go),
    .emit   (emit),
    .result (eng_result)
  );

  mndtf_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (go && emit),
    .load_result (eng_result),
    .busy        (busy),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .result      (out_result)
  );

  assign result.out_status = out_result.status;
  assign result.out_data1  = out_result.data1;
  assign result.out_data2  = out_result.data2;
  assign result.pedal_down = out_result.pedal_down;

  a_note_on_velocity_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.out_status[7:4] == MSG_NOTE_ON) |-> result.out_data2 != 7'd0)
    else $error("note-on result with zero velocity");

  a_note_on_velocity_capped: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.out_status[7:4] == MSG_NOTE_ON)
      |-> (result.out_data2 <= cfg_q.velocity_cap) || (result.out_data2 == 7'd1))
    else $error("note-on velocity above cap");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    item_valid && emit && busy |-> !midi.ready)
    else $error("input accepted while pending result is blocked");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !go |=> item_valid && $stable(item))
    else $error("stalled item lost or changed");

endmodule
